FILE: rtl/ipsw_pkg.sv
// Shared types, constants and helper functions of the indexed PNG stream writer.
// Used by the front stage, the command queue, the byte sequencer and the word packer.
package ipsw_pkg;

  localparam int PALETTE_ENTRIES = 25;
  localparam int DIM_BITS = 12;
  localparam int CFG_W = 13;
  localparam int RAW_W = 25;
  localparam logic [15:0] MAX_BLOCK = 16'hFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic       is_pixel;
    logic       bad;
    logic [7:0] pix;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       err;
  } byte_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] r;
    unique case (k)
      2'd0: r = v[31:24];
      2'd1: r = v[23:16];
      2'd2: r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  // Entries below sixteen follow the base colours; the next eight repeat the dim half.
  function automatic logic [7:0] pal_byte(input logic [4:0] ent, input logic [1:0] comp);
    logic       on;
    logic [7:0] r;
    unique case (comp)
      2'd0: on = ent[1];
      2'd1: on = ent[2];
      default: on = ent[0];
    endcase
    if (ent >= 5'd24) begin
      r = 8'd0;
    end else if (!on) begin
      r = 8'd0;
    end else begin
      r = (ent[3] && !ent[4]) ? 8'hFF : 8'hC0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/indexed_png_stored_stream_writer_top.sv
// Top level of the indexed PNG stream writer: front stage, command queue, byte
// sequencer and word packer. Depends on ipsw_pkg and the ipsw_* modules.
//
// A start transfer (tuser 0) produces the whole file head, 135 bytes in 34 words, at one byte
// per clock while the packer is ready; the sequencer takes each command from the queue and
// then produces its bytes: a pixel transfer one byte, a pixel at a row start a filter byte
// first, and a pixel that opens a stored block five block-header bytes more. The last pixel
// adds 20 bytes of trailer. A four-entry queue lets input transfers continue while the
// sequencer works. Output words carry the first byte in bits 31 to 24.
module indexed_png_stored_stream_writer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // pixel_value[7:0]
  input  logic [0:0]  s_tuser,   // mode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_word[31:0], byte_count[34:32], zero[39:35]
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // frame_done[0], error_flag[1]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import ipsw_pkg::*;

  logic  push, q_full, q_pop, q_empty, byte_ready;
  cmd_t  push_cmd, q_cmd;
  byte_t seq_byte;

  ipsw_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .push(push), .push_cmd(push_cmd),
    .q_full(q_full)
  );

  ipsw_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .full(q_full),
    .pop(q_pop), .pop_cmd(q_cmd), .empty(q_empty)
  );

  ipsw_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_empty(q_empty), .q_cmd(q_cmd), .q_pop(q_pop), .out_byte(seq_byte),
    .byte_ready(byte_ready)
  );

  ipsw_pack u_pack (
    .clk(clk), .rst(rst), .in_byte(seq_byte), .byte_ready(byte_ready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

endmodule

FILE: rtl/ipsw_front.sv
// Front stage: registers one input transfer and classifies it into a command.
// Depends on ipsw_pkg.
module ipsw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic [0:0]     s_tuser,
  output logic           push,
  output ipsw_pkg::cmd_t push_cmd,
  input  logic           q_full
);
  import ipsw_pkg::*;

  logic fvalid;
  cmd_t fcmd;

  assign s_tready = !fvalid || !q_full;
  assign push = fvalid && !q_full;
  assign push_cmd = fcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      fvalid <= 1'b1;
    end else if (push) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fcmd.is_pixel <= s_tuser[0];
      fcmd.pix <= s_tdata;
      fcmd.bad <= ({1'b0, s_tdata} >= 9'(PALETTE_ENTRIES));
    end
  end

endmodule

FILE: rtl/ipsw_queue.sv
// Short command queue between the front stage and the byte sequencer.
// Depends on ipsw_pkg.
module ipsw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ipsw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ipsw_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import ipsw_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a write");
`endif

endmodule

FILE: rtl/ipsw_pack.sv
// Word packer and output register: gathers sequencer bytes up to four to a word, closing a short word at an item's end.
// Depends on ipsw_pkg.
module ipsw_pack (
  input  logic            clk,
  input  logic            rst,
  input  ipsw_pkg::byte_t in_byte,
  output logic            byte_ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,
  output logic            m_tlast,
  output logic [1:0]      m_tuser
);
  import ipsw_pkg::*;

  logic [31:0] acc;
  logic [1:0]  cnt;
  logic [31:0] word;
  logic        flush;

  assign byte_ready = !m_tvalid || m_tready;
  assign flush = in_byte.valid && byte_ready && (cnt == 2'd3 || in_byte.last);

  always_comb begin
    unique case (cnt)
      2'd0: word = acc | {in_byte.data, 24'd0};
      2'd1: word = acc | {8'd0, in_byte.data, 16'd0};
      2'd2: word = acc | {16'd0, in_byte.data, 8'd0};
      default: word = acc | {24'd0, in_byte.data};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cnt <= '0;
      acc <= '0;
    end else begin
      if (flush) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_byte.valid && byte_ready) begin
        if (flush) begin
          acc <= '0;
          cnt <= '0;
        end else begin
          acc <= word;
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush) begin
      m_tdata <= {5'd0, {1'b0, cnt} + 3'd1, word};
      m_tlast <= in_byte.last;
      m_tuser <= {in_byte.err, in_byte.done};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= 3'd4))
    else $error("word byte count out of range");
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("frame end on a word that does not close its item");
  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[34:32] != 3'd4) |-> m_tlast)
    else $error("partial word before the end of an item");
`endif

endmodule

FILE: rtl/ipsw_back.sv
// Byte sequencer: executes queued commands and produces the PNG byte stream with CRC,
// Adler-32 and stored-block framing. Holds the frame size registers. Depends on ipsw_pkg.
module ipsw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [12:0]     cfg_data,
  input  logic            q_empty,
  input  ipsw_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output ipsw_pkg::byte_t out_byte,
  input  logic            byte_ready
);
  import ipsw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIG, ST_LEN, ST_TYPE, ST_IHDR, ST_PLTE, ST_CRC,
    ST_ZHDR, ST_BLKH, ST_RAW, ST_ADLER, ST_STRAY
  } state_t;
  typedef enum logic [1:0] {CK_IHDR, CK_PLTE, CK_IDAT, CK_IEND} chunk_t;
  typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_DONE} phase_t;

  logic [CFG_W-1:0] image_width, image_height;
  logic [CFG_W-1:0] eff_w, eff_h;
  logic [RAW_W-1:0] raw_r;
  logic [9:0]       blocks;
  logic [RAW_W-1:0] raw_d;
  logic [31:0]      idat_len;

  state_t           state;
  chunk_t           kind;
  phase_t           phase;
  logic [6:0]       idx;
  logic [4:0]       ent;
  logic [1:0]       comp;
  logic [CFG_W-1:0] column_count;
  logic [15:0]      block_bytes_left;
  logic [RAW_W-1:0] raw_bytes_left;
  logic [31:0]      running_crc;
  logic [15:0]      adler_low, adler_high;
  logic             frame_error;
  logic             item_err;
  logic [7:0]       pix;
  logic             raw_idx;
  logic             blk_ret_raw;

  logic [31:0]      crc_in;
  logic [7:0]       b;
  logic             use_crc;
  logic             b_last;
  logic             b_done;
  logic             adv;
  logic [15:0]      blk;
  logic [16:0]      low_sum, high_sum;
  logic [15:0]      low_n;
  logic [31:0]      len_val;
  logic [7:0]       type_b;
  logic [16:0]      rsum;
  logic [8:0]       q0;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(1 << DIM_BITS)) begin
      r = CFG_W'(1 << DIM_BITS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration and frame size arithmetic, settled long before the sequencer needs it.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= CFG_W'(256);
      image_height <= CFG_W'(192);
    end else if (cfg_we && phase != PH_DATA) begin
      if (cfg_index == REG_WIDTH) begin
        image_width <= cfg_data;
      end else if (cfg_index == REG_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  assign q0 = raw_r[24:16];
  assign rsum = {1'b0, raw_r[15:0]} + {8'd0, q0};

  always_ff @(posedge clk) begin
    eff_w <= eff_dim(image_width);
    eff_h <= eff_dim(image_height);
    raw_r <= RAW_W'(eff_h * ({1'b0, eff_w} + 14'd1));
    raw_d <= raw_r;
    if (rsum >= {1'b0, MAX_BLOCK}) begin
      blocks <= {1'b0, q0} + 10'd1 + ((rsum - {1'b0, MAX_BLOCK}) != 17'd0 ? 10'd1 : 10'd0);
    end else begin
      blocks <= {1'b0, q0} + (rsum != 17'd0 ? 10'd1 : 10'd0);
    end
    idat_len <= 32'(raw_d) + 32'd6 + {20'd0, blocks, 2'b00} + {22'd0, blocks};
  end

  assign blk = (raw_bytes_left > {9'd0, MAX_BLOCK}) ? MAX_BLOCK : raw_bytes_left[15:0];
  assign crc_in = (state == ST_TYPE && idx == 7'd0) ? 32'hFFFFFFFF : running_crc;
  assign low_sum = {1'b0, adler_low} + {9'd0, b};
  assign low_n = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
  assign high_sum = {1'b0, adler_high} + {1'b0, low_n};

  always_comb begin
    unique case (kind)
      CK_IHDR: len_val = 32'd13;
      CK_PLTE: len_val = 32'(PALETTE_ENTRIES * 3);
      CK_IDAT: len_val = idat_len;
      default: len_val = 32'd0;
    endcase
    unique case (kind)
      CK_IHDR: type_b = be_byte(32'h49484452, idx[1:0]);
      CK_PLTE: type_b = be_byte(32'h504C5445, idx[1:0]);
      CK_IDAT: type_b = be_byte(32'h49444154, idx[1:0]);
      default: type_b = be_byte(32'h49454E44, idx[1:0]);
    endcase
  end

  always_comb begin
    b = 8'd0;
    use_crc = 1'b1;
    b_last = 1'b0;
    b_done = 1'b0;
    unique case (state)
      ST_SIG: begin
        use_crc = 1'b0;
        b = idx[2] ? be_byte(32'h0D0A1A0A, idx[1:0]) : be_byte(32'h89504E47, idx[1:0]);
      end
      ST_LEN: begin
        use_crc = 1'b0;
        b = be_byte(len_val, idx[1:0]);
      end
      ST_TYPE: b = type_b;
      ST_IHDR: begin
        if (idx < 7'd4) begin
          b = be_byte({19'd0, eff_w}, idx[1:0]);
        end else if (idx < 7'd8) begin
          b = be_byte({19'd0, eff_h}, idx[1:0]);
        end else if (idx == 7'd8) begin
          b = 8'd8;
        end else if (idx == 7'd9) begin
          b = 8'd3;
        end
      end
      ST_PLTE: b = pal_byte(ent, comp);
      ST_CRC: begin
        use_crc = 1'b0;
        b = be_byte(~running_crc, idx[1:0]);
        b_last = (kind == CK_IEND && idx == 7'd3);
        b_done = b_last;
      end
      ST_ZHDR: b = (idx == 7'd0) ? 8'h78 : 8'h01;
      ST_BLKH: begin
        unique case (idx[2:0])
          3'd0: b = {7'd0, raw_bytes_left[24:16] == 9'd0};
          3'd1: b = blk[7:0];
          3'd2: b = blk[15:8];
          3'd3: b = ~blk[7:0];
          default: b = ~blk[15:8];
        endcase
        b_last = (idx == 7'd4) && !blk_ret_raw;
      end
      ST_RAW: begin
        b = raw_idx ? pix : 8'd0;
        b_last = raw_idx && (raw_bytes_left != RAW_W'(1));
      end
      ST_ADLER: b = be_byte({adler_high, adler_low}, idx[1:0]);
      ST_STRAY: begin
        use_crc = 1'b0;
        b = pix;
        b_last = 1'b1;
      end
      default: use_crc = 1'b0;
    endcase
  end

  assign adv = (state != ST_IDLE) && byte_ready;
  assign q_pop = (state == ST_IDLE) && !q_empty;

  assign out_byte.valid = (state != ST_IDLE);
  assign out_byte.data = b;
  assign out_byte.last = b_last;
  assign out_byte.done = b_done;
  assign out_byte.err = item_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_IDLE;
      kind <= CK_IHDR;
      idx <= '0;
      ent <= '0;
      comp <= '0;
      column_count <= '0;
      block_bytes_left <= '0;
      raw_bytes_left <= '0;
      running_crc <= 32'hFFFFFFFF;
      adler_low <= 16'd1;
      adler_high <= 16'd0;
      frame_error <= 1'b0;
      item_err <= 1'b0;
      raw_idx <= 1'b0;
      blk_ret_raw <= 1'b0;
      pix <= '0;
    end else if (q_pop) begin
      pix <= q_cmd.pix;
      idx <= '0;
      if (!q_cmd.is_pixel) begin
        state <= ST_SIG;
        phase <= PH_DATA;
        kind <= CK_IHDR;
        column_count <= '0;
        block_bytes_left <= '0;
        frame_error <= 1'b0;
        item_err <= 1'b0;
        adler_low <= 16'd1;
        adler_high <= 16'd0;
      end else if (phase != PH_DATA) begin
        state <= ST_STRAY;
        item_err <= 1'b1;
      end else begin
        frame_error <= frame_error | q_cmd.bad;
        item_err <= frame_error | q_cmd.bad;
        raw_idx <= (column_count != '0);
        blk_ret_raw <= 1'b1;
        state <= (block_bytes_left == '0) ? ST_BLKH : ST_RAW;
      end
    end else if (adv) begin
      if (use_crc) begin
        running_crc <= crc_byte(crc_in, b);
      end
      idx <= idx + 1'b1;
      unique case (state)
        ST_SIG: begin
          if (idx == 7'd7) begin
            state <= ST_LEN;
            idx <= '0;
          end
        end
        ST_LEN: begin
          if (idx == 7'd3) begin
            state <= ST_TYPE;
            idx <= '0;
          end
        end
        ST_TYPE: begin
          if (idx == 7'd3) begin
            idx <= '0;
            ent <= '0;
            comp <= '0;
            unique case (kind)
              CK_IHDR: state <= ST_IHDR;
              CK_PLTE: state <= ST_PLTE;
              CK_IDAT: begin
                state <= ST_ZHDR;
                raw_bytes_left <= raw_r;
              end
              default: state <= ST_CRC;
            endcase
          end
        end
        ST_IHDR: begin
          if (idx == 7'd12) begin
            state <= ST_CRC;
            idx <= '0;
          end
        end
        ST_PLTE: begin
          if (comp == 2'd2) begin
            comp <= '0;
            ent <= ent + 1'b1;
            if (ent == 5'(PALETTE_ENTRIES - 1)) begin
              state <= ST_CRC;
              idx <= '0;
            end
          end else begin
            comp <= comp + 1'b1;
          end
        end
        ST_CRC: begin
          if (idx == 7'd3) begin
            idx <= '0;
            unique case (kind)
              CK_IHDR: begin
                kind <= CK_PLTE;
                state <= ST_LEN;
              end
              CK_PLTE: begin
                kind <= CK_IDAT;
                state <= ST_LEN;
              end
              CK_IDAT: begin
                kind <= CK_IEND;
                state <= ST_LEN;
              end
              default: begin
                phase <= PH_DONE;
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_ZHDR: begin
          if (idx == 7'd1) begin
            state <= ST_BLKH;
            blk_ret_raw <= 1'b0;
            idx <= '0;
          end
        end
        ST_BLKH: begin
          if (idx == 7'd4) begin
            block_bytes_left <= blk;
            idx <= '0;
            state <= blk_ret_raw ? ST_RAW : ST_IDLE;
          end
        end
        ST_RAW: begin
          adler_low <= low_n;
          adler_high <= (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
          block_bytes_left <= block_bytes_left - 1'b1;
          raw_bytes_left <= raw_bytes_left - 1'b1;
          idx <= '0;
          if (!raw_idx) begin
            raw_idx <= 1'b1;
            if (block_bytes_left == 16'd1) begin
              state <= ST_BLKH;
              blk_ret_raw <= 1'b1;
            end
          end else begin
            if ({1'b0, column_count} + 14'd1 >= {1'b0, eff_w}) begin
              column_count <= '0;
            end else begin
              column_count <= column_count + 1'b1;
            end
            state <= (raw_bytes_left == RAW_W'(1)) ? ST_ADLER : ST_IDLE;
          end
        end
        ST_ADLER: begin
          if (idx == 7'd3) begin
            state <= ST_CRC;
            idx <= '0;
          end
        end
        ST_STRAY: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_block_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLKH) |-> (raw_bytes_left != '0))
    else $error("stored block opened with no raw bytes left");
  a_raw_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RAW) |-> (block_bytes_left != '0 && raw_bytes_left != '0))
    else $error("raw byte outside a stored block");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != ST_IDLE))
    else $error("command taken without work");
`endif

endmodule

FILE: sim/indexed_png_stored_stream_writer_top_test.sv
// Self-checking testbench for indexed_png_stored_stream_writer_top: a scoreboard class predicts
// the PNG byte stream of every accepted transfer and checks the output words in order.
// Depends on ipsw_pkg and the RTL of the stream writer.
module indexed_png_stored_stream_writer_top_test;
  import ipsw_pkg::*;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;
  localparam int PH_IDLE = 0;
  localparam int PH_DATA = 1;
  localparam int PH_DONE = 2;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  count;
    bit        last;
    bit        done;
    bit        err;
  } png_word_t;

  class png_scoreboard;
    png_word_t  expected_words[$];
    bit [7:0]   bytes[$];
    bit [12:0]  width_reg = 13'd256;
    bit [12:0]  height_reg = 13'd192;
    int         phase = PH_IDLE;
    bit [12:0]  col;
    bit [12:0]  row;
    bit [15:0]  blk_left;
    bit [24:0]  raw_left;
    bit [31:0]  crc = 32'hFFFF_FFFF;
    int         a_lo = 1;
    int         a_hi = 0;
    bit         ferr;
    int         errors;
    bit [7:0]   base_rgb [16][3] = '{
      '{0, 0, 0}, '{0, 0, 192}, '{192, 0, 0}, '{192, 0, 192},
      '{0, 192, 0}, '{0, 192, 192}, '{192, 192, 0}, '{192, 192, 192},
      '{0, 0, 0}, '{0, 0, 255}, '{255, 0, 0}, '{255, 0, 255},
      '{0, 255, 0}, '{0, 255, 255}, '{255, 255, 0}, '{255, 255, 255}};

    function int dim(bit [12:0] v);
      if (v == 0) return 1;
      return (v > (1 << DIM_BITS)) ? (1 << DIM_BITS) : int'(v);
    endfunction

    function void put(bit [7:0] b, bit with_crc);
      bytes.push_back(b);
      if (with_crc) begin
        crc = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) crc = (crc >> 1) ^ (32'hEDB88320 & {32{crc[0]}});
      end
    endfunction

    function void put_word(bit [31:0] v, bit with_crc);
      for (int i = 3; i >= 0; i--) put(v[8*i +: 8], with_crc);
    endfunction

    function void chunk(bit [31:0] len, bit [31:0] tag);
      put_word(len, 0);
      crc = 32'hFFFF_FFFF;
      put_word(tag, 1);
    endfunction

    function void block_header();
      bit [15:0] blk;
      blk = (raw_left > 65535) ? 16'hFFFF : raw_left[15:0];
      put((blk == raw_left) ? 8'd1 : 8'd0, 1);
      put(blk[7:0], 1);
      put(blk[15:8], 1);
      put(~blk[7:0], 1);
      put(~blk[15:8], 1);
      blk_left = blk;
    endfunction

    function void data_byte(bit [7:0] b);
      if (raw_left == 0) return;
      if (blk_left == 0) block_header();
      put(b, 1);
      a_lo = (a_lo + b) % 65521;
      a_hi = (a_hi + a_lo) % 65521;
      blk_left--;
      raw_left--;
    endfunction

    function void open_frame();
      int w;
      int h;
      int raw;
      int blocks;
      w = dim(width_reg);
      h = dim(height_reg);
      raw = h * (w + 1);
      blocks = (raw + 65534) / 65535;
      phase = PH_DATA;
      col = 0;
      row = 0;
      blk_left = 0;
      raw_left = 25'(raw);
      ferr = 0;
      a_lo = 1;
      a_hi = 0;
      put_word(32'h89504E47, 0);
      put_word(32'h0D0A1A0A, 0);
      chunk(13, "IHDR");
      put_word(w, 1);
      put_word(h, 1);
      put(8, 1); put(3, 1); put(0, 1); put(0, 1); put(0, 1);
      put_word(~crc, 0);
      chunk(PALETTE_ENTRIES * 3, "PLTE");
      for (int i = 0; i < PALETTE_ENTRIES; i++)
        for (int c = 0; c < 3; c++)
          put((i < 16) ? base_rgb[i][c] : (i < 24) ? base_rgb[i-16][c] : 8'd0, 1);
      put_word(~crc, 0);
      chunk(raw + 6 + blocks * 5, "IDAT");
      put(8'h78, 1);
      put(8'h01, 1);
      block_header();
    endfunction

    function void note_config(bit [1:0] idx, bit [12:0] val);
      if (phase == PH_DATA) return;
      if (idx == REG_WIDTH) width_reg = val;
      else if (idx == REG_HEIGHT) height_reg = val;
    endfunction

    function void note_input(bit mode, bit [7:0] pix);
      bit ended;
      int n;
      png_word_t r;
      ended = 0;
      bytes.delete();
      if (mode == MODE_START) begin
        open_frame();
      end else if (phase != PH_DATA) begin
        r.word = {pix, 24'd0};
        r.count = 1;
        r.last = 1;
        r.done = 0;
        r.err = 1;
        expected_words.push_back(r);
        return;
      end else begin
        if (pix >= PALETTE_ENTRIES) ferr = 1;
        if (col == 0) data_byte(0);
        data_byte(pix);
        col++;
        if (col >= dim(width_reg)) begin
          col = 0;
          row++;
        end
        if (raw_left == 0) begin
          put(a_hi[15:8], 1); put(a_hi[7:0], 1);
          put(a_lo[15:8], 1); put(a_lo[7:0], 1);
          put_word(~crc, 0);
          chunk(0, "IEND");
          put_word(~crc, 0);
          phase = PH_DONE;
          ended = 1;
        end
      end
      n = (bytes.size() + 3) / 4;
      for (int k = 0; k < n; k++) begin
        r.word = 0;
        r.count = (bytes.size() - 4 * k > 4) ? 4 : bytes.size() - 4 * k;
        for (int j = 0; j < r.count; j++) r.word[31 - 8*j -: 8] = bytes[4*k + j];
        r.last = (k == n - 1);
        r.done = (k == n - 1) && ended;
        r.err = ferr;
        expected_words.push_back(r);
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check(bit [31:0] word, bit [2:0] count, bit last, bit done, bit err);
      png_word_t e;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h count %0d", word, count));
        return;
      end
      e = expected_words.pop_front();
      if (word !== e.word) report($sformatf("word %h, want %h", word, e.word));
      if (count !== e.count) report($sformatf("count %0d, want %0d", count, e.count));
      if (last !== e.last) report($sformatf("last %0d, want %0d", last, e.last));
      if (done !== e.done) report($sformatf("frame_done %0d, want %0d", done, e.done));
      if (err !== e.err) report($sformatf("error_flag %0d, want %0d", err, e.err));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic [0:0]  s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [12:0] cfg_data = 0;

  png_scoreboard sb = new();
  int  cycles;
  int  hold_cycles;
  bit  no_idle;

  indexed_png_stored_stream_writer_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (!rst && m_tvalid && m_tready)
      sb.check(m_tdata[31:0], m_tdata[34:32], m_tlast, m_tuser[0], m_tuser[1]);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 0;
        hold_cycles--;
      end else begin
        m_tready <= (pick_gap() == 0);
      end
    end
  end

  task automatic send(bit mode, bit [7:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(mode, pix);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(bit [1:0] idx, bit [12:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.note_config(idx, val);
  endtask

  task automatic frame(bit [12:0] w, bit [12:0] h, int pixels, int bad_pct);
    write_cfg(REG_WIDTH, w);
    write_cfg(REG_HEIGHT, h);
    send(MODE_START, 8'($urandom));
    for (int i = 0; i < pixels; i++)
      send(MODE_PIXEL, ($urandom_range(0, 99) < bad_pct) ?
           8'($urandom_range(25, 255)) : 8'($urandom_range(0, 24)));
  endtask

  initial begin
    int w;
    int h;
    repeat (8) @(posedge clk);
    rst <= 0;
    // Pixels with no open frame, then the smallest frame and a stray pixel after it.
    send(MODE_PIXEL, 8'd255);
    send(MODE_PIXEL, 8'd0);
    frame(13'd0, 13'd0, 0, 0);
    send(MODE_PIXEL, 8'd24);
    send(MODE_PIXEL, 8'd25);
    // An invalid index, a write while the frame is open and an abandoned frame.
    frame(13'd3, 13'd2, 2, 0);
    send(MODE_PIXEL, 8'd25);
    write_cfg(REG_WIDTH, 13'd5);
    send(MODE_START, 8'd0);
    for (int i = 0; i < 6; i++) send(MODE_PIXEL, 8'(i * 4));
    // The receiver holds off while the sender keeps offering.
    write_cfg(REG_WIDTH, 13'd4097);
    write_cfg(REG_HEIGHT, 13'd1);
    hold_cycles = 400;
    send(MODE_START, 8'd0);
    for (int i = 0; i < 20; i++) send(MODE_PIXEL, 8'($urandom_range(0, 24)));
    drain();
    write_cfg(REG_HEIGHT, 13'd8191);
    frame(13'd1, 13'd8191, 0, 0);
    for (int i = 0; i < 10; i++) send(MODE_PIXEL, (i == 5) ? 8'd255 : 8'd7);
    send(MODE_START, 8'd0);
    no_idle = 1;
    for (int i = 0; i < 20; i++) send(MODE_PIXEL, 8'($urandom_range(0, 24)));
    no_idle = 0;
    repeat (30) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 3);
      if ($urandom_range(0, 5) == 0) no_idle = 1;
      frame(13'(w), 13'(h), ($urandom_range(0, 6) == 0) ? $urandom_range(0, w * h - 1) : w * h,
            10);
      if ($urandom_range(0, 3) == 0) send(MODE_PIXEL, 8'($urandom));
      no_idle = 0;
    end
    // Width beyond the limit with sixteen rows needs more than one stored block.
    no_idle = 1;
    frame(13'd8191, 13'd16, 20, 1);
    no_idle = 0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
